// ===== hdl/gcs_pkg.sv =====
// Shared types and constants for the gray contrast stretch block.
// Used by every module under hdl/; depends on nothing else.
package gcs_pkg;

   // Byte range of luma, curve and palette levels
   localparam int unsigned LEVEL_W   = 8;
   localparam int unsigned LEVEL_MAX = 255;
   localparam int unsigned LEVELS    = 2 ** LEVEL_W;

   // Default knee of the bluish palette
   localparam int unsigned BLUE_KNEE_DEF = 80;

   // Divider layout: 16 quotient bits, four bits per pipeline stage
   localparam int unsigned QUO_W          = 16;
   localparam int unsigned BITS_PER_STAGE = 4;
   localparam int unsigned DIV_STAGES     = QUO_W / BITS_PER_STAGE;

   // CSR register indexes
   typedef enum logic [2:0] {
      CSR_BREAK_LOW_IN   = 3'd0,
      CSR_BREAK_MID_IN   = 3'd1,
      CSR_BREAK_HIGH_IN  = 3'd2,
      CSR_LEVEL_LOW_OUT  = 3'd3,
      CSR_LEVEL_MID_OUT  = 3'd4,
      CSR_LEVEL_HIGH_OUT = 3'd5,
      CSR_BLUISH_PALETTE = 3'd6
   } csr_index_type;

   // Input word: one RGB pixel
   typedef struct packed {
      logic [7:0] pix_red;
      logic [7:0] pix_green;
      logic [7:0] pix_blue;
   } pix_type;

   // Output word: palette index and its color
   typedef struct packed {
      logic [7:0] mapped_level;
      logic [7:0] shown_red;
      logic [7:0] shown_green;
      logic [7:0] shown_blue;
   } gray_type;

   // Curve and palette settings
   typedef struct packed {
      logic [7:0] break_low_in;
      logic [7:0] break_mid_in;
      logic [7:0] break_high_in;
      logic [7:0] level_low_out;
      logic [7:0] level_mid_out;
      logic [7:0] level_high_out;
      logic       bluish_palette;
   } curve_cfg_type;

   localparam curve_cfg_type CFG_RESET = '{
      break_low_in:   8'd0,
      break_mid_in:   8'd128,
      break_high_in:  8'd255,
      level_low_out:  8'd0,
      level_mid_out:  8'd128,
      level_high_out: 8'd255,
      bluish_palette: 1'b0
   };

   // Segment operands after selection
   typedef struct packed {
      logic signed [8:0] diff_y;    // yb - ya
      logic signed [8:0] diff_x;    // luma - xa
      logic [7:0]        den;       // |xb - xa|
      logic              den_neg;
      logic [7:0]        ya;
      logic [7:0]        yb;
   } seg_type;

   // Divider working word; work shifts dividend out and quotient in
   typedef struct packed {
      logic [7:0]       rem;
      logic [QUO_W-1:0] work;
      logic [7:0]       den;
      logic             neg;
      logic [7:0]       ya;
      logic [7:0]       yb;
   } div_type;

   // One restoring division step
   function automatic div_type div_step(input div_type d);
      div_type   r;
      logic [8:0] trial;
      r     = d;
      trial = {d.rem, d.work[QUO_W-1]};
      r.work = {d.work[QUO_W-2:0], 1'b0};
      if (trial >= {1'b0, d.den}) begin
         r.rem     = 8'(trial - {1'b0, d.den});
         r.work[0] = 1'b1;
      end else begin
         r.rem = trial[7:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/gray_contrast_stretch.sv =====
// Channel   Dir  Handshake        Payload
// req_      in   valid / stall    pix_type (pix_red, pix_green, pix_blue)
// rsp_      out  valid / stall    gray_type (mapped_level, shown_*)
// csr_      in   valid / ready    csr_index (3 bits), csr_wdata (8 bits)
//
// One word per clock sustained while rsp_stall is low. The pipe has 3 front
// stages (luma, segment select, multiply), 4 divider stages of 4 quotient bits
// each, and 2 back stages (clamp, palette into the output register).
// Synchronous reset clears all stage valid bits and loads the default curve.
// A stall on rsp_ backs up stage by stage; req_stall rises only once every
// stage holds a word. csr_ready is always high; a write lands next cycle.
// Top level of the contrast stretch; instantiates gcs_front, gcs_divider
// and gcs_map, and holds the CSRs. Uses gcs_pkg.
module gray_contrast_stretch import gcs_pkg::*; #(
   parameter int unsigned BLUE_KNEE = BLUE_KNEE_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  pix_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output gray_type   rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   curve_cfg_type cfg_ff, cfg_in;
   logic          front_valid, front_stall;
   div_type       front_data;
   logic          div_valid, div_stall;
   div_type       div_data;

   // CSR write decode
   assign csr_ready = 1'b1;
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BREAK_LOW_IN:   cfg_in.break_low_in   = csr_wdata;
            CSR_BREAK_MID_IN:   cfg_in.break_mid_in   = csr_wdata;
            CSR_BREAK_HIGH_IN:  cfg_in.break_high_in  = csr_wdata;
            CSR_LEVEL_LOW_OUT:  cfg_in.level_low_out  = csr_wdata;
            CSR_LEVEL_MID_OUT:  cfg_in.level_mid_out  = csr_wdata;
            CSR_LEVEL_HIGH_OUT: cfg_in.level_high_out = csr_wdata;
            CSR_BLUISH_PALETTE: cfg_in.bluish_palette = csr_wdata[0];
            default:            cfg_in = cfg_ff;   // unmapped index ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gcs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_data   (req_data),
      .out_valid (front_valid),
      .out_stall (front_stall),
      .out_data  (front_data)
   );

   gcs_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_stall  (front_stall),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_stall (div_stall),
      .out_data  (div_data)
   );

   gcs_map #(
      .BLUE_KNEE (BLUE_KNEE)
   ) u_map (
      .clock          (clock),
      .reset          (reset),
      .bluish_palette (cfg_ff.bluish_palette),
      .in_valid       (div_valid),
      .in_stall       (div_stall),
      .in_data        (div_data),
      .out_valid      (rsp_valid),
      .out_stall      (rsp_stall),
      .out_data       (rsp_data)
   );

   // Nothing leaves the pipe in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result word valid right after reset");

endmodule

// ===== hdl/gcs_front.sv =====
// Front end: luma, segment selection and the numerator product.
// Three register stages; uses gcs_pkg.
module gcs_front import gcs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  curve_cfg_type cfg,
   input  logic          in_valid,
   output logic          in_stall,
   input  pix_type       in_data,
   output logic          out_valid,
   input  logic          out_stall,
   output div_type       out_data
);

   logic       v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in;
   logic       hold1, hold2, hold3;
   logic [7:0] lum_ff, lum_in;
   seg_type    seg_ff, seg_in;
   div_type    div_ff, div_in;

   // Stage hold chain: a stage holds only if it is full and the next holds
   assign hold3    = v3_ff && out_stall;
   assign hold2    = v2_ff && hold3;
   assign hold1    = v1_ff && hold2;
   assign in_stall = hold1;

   assign v1_in = hold1 ? v1_ff : in_valid;
   assign v2_in = hold2 ? v2_ff : v1_ff;
   assign v3_in = hold3 ? v3_ff : v2_ff;

   // Stage 1: luma = (2g + r + b) / 4
   always_comb begin
      logic [9:0] sum;
      sum    = {1'b0, in_data.pix_green, 1'b0} + {2'b00, in_data.pix_red}
               + {2'b00, in_data.pix_blue};
      lum_in = hold1 ? lum_ff : sum[9:2];
   end

   // Stage 2: pick the segment and form the differences
   always_comb begin
      logic              first_seg;
      logic [7:0]        xa, xb, ya, yb;
      logic signed [8:0] dx, dx_abs;
      first_seg = lum_ff < cfg.break_mid_in;
      xa = first_seg ? cfg.break_low_in  : cfg.break_mid_in;
      xb = first_seg ? cfg.break_mid_in  : cfg.break_high_in;
      ya = first_seg ? cfg.level_low_out : cfg.level_mid_out;
      yb = first_seg ? cfg.level_mid_out : cfg.level_high_out;
      dx     = $signed({1'b0, xb}) - $signed({1'b0, xa});
      dx_abs = dx[8] ? -dx : dx;
      seg_in = seg_ff;
      if (!hold2) begin
         seg_in.diff_y  = $signed({1'b0, yb}) - $signed({1'b0, ya});
         seg_in.diff_x  = $signed({1'b0, lum_ff}) - $signed({1'b0, xa});
         seg_in.den     = dx_abs[7:0];
         seg_in.den_neg = dx[8];
         seg_in.ya      = ya;
         seg_in.yb      = yb;
      end
   end

   // Stage 3: signed product, split into magnitude and quotient sign
   always_comb begin
      logic signed [17:0] prod, prod_abs;
      prod     = seg_ff.diff_y * seg_ff.diff_x;
      prod_abs = prod[17] ? -prod : prod;
      div_in   = div_ff;
      if (!hold3) begin
         div_in.rem  = '0;
         div_in.work = prod_abs[QUO_W-1:0];
         div_in.den  = seg_ff.den;
         div_in.neg  = prod[17] ^ seg_ff.den_neg;
         div_in.ya   = seg_ff.ya;
         div_in.yb   = seg_ff.yb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   always_ff @(posedge clock) begin
      lum_ff <= lum_in;
      seg_ff <= seg_in;
      div_ff <= div_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = div_ff;

endmodule

// ===== hdl/gcs_divider.sv =====
// Pipelined restoring divider, four quotient bits (BITS_PER_STAGE) per stage.
// Divides the product magnitude by the segment width; uses gcs_pkg.
module gcs_divider import gcs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  div_type in_data,
   output logic    out_valid,
   input  logic    out_stall,
   output div_type out_data
);

   logic [DIV_STAGES-1:0] v_ff, v_in, hold, src_v;
   div_type               div_ff [DIV_STAGES];
   div_type               div_in [DIV_STAGES];
   div_type               src_d  [DIV_STAGES];

   // Hold chain from the output back to the input
   always_comb begin
      hold[DIV_STAGES-1] = v_ff[DIV_STAGES-1] && out_stall;
      for (int k = DIV_STAGES - 2; k >= 0; k--) begin
         hold[k] = v_ff[k] && hold[k+1];
      end
   end
   assign in_stall = hold[0];

   // Each stage runs BITS_PER_STAGE division steps on its source word
   always_comb begin
      div_type t;
      src_v[0] = in_valid;
      src_d[0] = in_data;
      for (int k = 1; k < DIV_STAGES; k++) begin
         src_v[k] = v_ff[k-1];
         src_d[k] = div_ff[k-1];
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         t = src_d[k];
         for (int s = 0; s < BITS_PER_STAGE; s++) begin
            t = div_step(t);
         end
         v_in[k]   = hold[k] ? v_ff[k]   : src_v[k];
         div_in[k] = hold[k] ? div_ff[k] : t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
         div_ff[k] <= div_in[k];
      end
   end

   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_data  = div_ff[DIV_STAGES-1];

   // Partial remainder always stays below a nonzero divisor
   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_chk
      a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
         v_ff[k] && (div_ff[k].den != '0) |-> div_ff[k].rem < div_ff[k].den)
         else $error("divider remainder not below divisor");
   end

endmodule

// ===== hdl/gcs_map.sv =====
// Back end: signed quotient plus offset, clamp, then palette lookup.
// Two register stages, the second is the output register; uses gcs_pkg.
module gcs_map import gcs_pkg::*; #(
   parameter int unsigned BLUE_KNEE = BLUE_KNEE_DEF
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     bluish_palette,
   input  logic     in_valid,
   output logic     in_stall,
   input  div_type  in_data,
   output logic     out_valid,
   input  logic     out_stall,
   output gray_type out_data
);

   localparam int Span = (BLUE_KNEE < LEVEL_MAX) ? int'(LEVEL_MAX - BLUE_KNEE) : 1;

   logic       va_ff, va_in, vb_ff, vb_in;
   logic       hold_a, hold_b;
   logic [7:0] lvl_ff, lvl_in;
   gray_type   rsp_ff, rsp_in;
   logic [7:0] shade_tab [LEVELS];

   // Bluish shade per level, built at elaboration
   for (genvar gi = 0; gi < LEVELS; gi++) begin : g_shade
      localparam int Raw   = (gi - int'(BLUE_KNEE)) * int'(LEVEL_MAX) / Span;
      localparam int Shade = (BLUE_KNEE >= LEVEL_MAX) ? int'(LEVEL_MAX) :
                             (Raw < 0) ? 0 :
                             (Raw > int'(LEVEL_MAX)) ? int'(LEVEL_MAX) : Raw;
      assign shade_tab[gi] = 8'(Shade);
   end

   assign hold_b   = vb_ff && out_stall;
   assign hold_a   = va_ff && hold_b;
   assign in_stall = hold_a;
   assign va_in    = hold_a ? va_ff : in_valid;
   assign vb_in    = hold_b ? vb_ff : va_ff;

   // Stage A: apply quotient sign, add segment start level, clamp; a zero-width segment takes its end level
   always_comb begin
      logic signed [17:0] quo_s, level_s;
      quo_s   = in_data.neg ? -$signed({2'b00, in_data.work})
                            :  $signed({2'b00, in_data.work});
      level_s = quo_s + $signed({10'd0, in_data.ya});
      lvl_in  = lvl_ff;
      if (!hold_a) begin
         if (in_data.den == '0) begin
            lvl_in = in_data.yb;          // zero-width segment
         end else if (level_s < 0) begin
            lvl_in = '0;
         end else if (level_s > $signed(18'(LEVEL_MAX))) begin
            lvl_in = 8'(LEVEL_MAX);
         end else begin
            lvl_in = level_s[7:0];
         end
      end
   end

   // Stage B: palette color into the output register
   always_comb begin
      logic [7:0] shade;
      shade  = bluish_palette ? shade_tab[lvl_ff] : lvl_ff;
      rsp_in = rsp_ff;
      if (!hold_b) begin
         rsp_in.mapped_level = lvl_ff;
         rsp_in.shown_red    = shade;
         rsp_in.shown_green  = shade;
         rsp_in.shown_blue   = lvl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vb_ff <= vb_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;
      rsp_ff <= rsp_in;
   end

   assign out_valid = vb_ff;
   assign out_data  = rsp_ff;

   // Gray palette: every channel carries the level
   a_gray_palette: assert property (@(posedge clock) disable iff (reset)
      out_valid && !bluish_palette |->
         out_data.shown_red == out_data.mapped_level &&
         out_data.shown_green == out_data.mapped_level)
      else $error("gray palette color differs from level");

   // Bluish palette: levels at or below the knee show no red or green
   a_knee_black: assert property (@(posedge clock) disable iff (reset)
      out_valid && bluish_palette && (BLUE_KNEE < LEVEL_MAX) &&
      (out_data.mapped_level <= BLUE_KNEE) |->
         out_data.shown_red == '0 && out_data.shown_green == '0)
      else $error("bluish shade nonzero below knee");

   // Red and green always match
   a_red_green: assert property (@(posedge clock) disable iff (reset)
      out_valid |-> out_data.shown_red == out_data.shown_green)
      else $error("red and green palette channels differ");

endmodule
